### design/xbf_pkg.sv
// xbf_pkg: shared types, line symbols and the crc-16 byte update for the
// xmodem block framer. No dependencies.
`default_nettype none

package xbf_pkg;

	// data bytes carried in one block
	localparam int BLOCK_BYTES = 128;
	// fill count must hold the block size itself
	localparam int FILL_W = $clog2(BLOCK_BYTES + 1);
	localparam int REP_W = 7;
	localparam int Q_DEPTH = 2;

	localparam logic [7:0] SYM_SOH = 8'h01;
	localparam logic [7:0] SYM_EOT = 8'h04;
	localparam logic [7:0] SYM_PAD = 8'h1A;
	localparam logic [15:0] CRC_POLY = 16'h1021;

	typedef struct packed {
		logic cmd;
		logic [7:0] data_byte;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic [REP_W-1:0] repeat_count;
		logic block_end;
		logic last;
	} out_item_t;

	typedef enum logic {
		OP_DATA = 1'b0,
		OP_EOF = 1'b1
	} op_t;

	typedef struct packed {
		op_t op;
		logic [7:0] data_byte;
	} q_entry_t;

	// crc-16/xmodem, msb first, one byte
	function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int i = 0; i < 8; i++) begin
			if (c[15]) begin
				c = {c[14:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[14:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

`default_nettype wire

### design/xmodem_block_framer_top.sv
// xmodem_block_framer_top: xmodem sender block framer, top level with the
// trailer mode register. Depends on xbf_pkg, xbf_front and xbf_back.
`default_nettype none

// Turns a file, given one byte per input beat and closed by an end-of-file
// beat, into the xmodem sender byte stream: SOH, block number, its complement,
// 128 data bytes and a trailer per block, which is an 8-bit additive checksum
// or, with use_crc set, a crc-16 (0x1021, init 0, high byte first). A short
// final block is padded with 0x1A, sent as one output beat whose repeat_count
// gives the number of pad bytes, then closed; two EOT beats end the file and
// the block number starts again at 1. block_end marks the final trailer byte
// of a block and last marks the final output beat of each input beat.
// Beats: a data byte in the middle of a block gives one output beat; the first
// byte of a block gives four (three header beats ahead of it), the byte that
// fills a block two or three (trailer beats after it). End of file gives up to
// five output beats, and the padding is folded into the accumulators one pad
// byte a cycle, with no output beat. The sequencer in xbf_back puts out at
// most one beat per cycle. A two-entry queue in xbf_front keeps taking input
// beats, until it is full, while the sequencer works or the output is stalled.
// The trailer mode is written through the cfg port, which is always ready, and
// should only change while the framer is idle.
module xmodem_block_framer_top (
	input wire logic clk,
	input wire logic arst_n,
	// trailer mode register write
	input wire logic cfg_valid,
	output logic cfg_ready,
	input wire logic cfg_data,
	// input items
	input wire logic in_valid,
	output logic in_ready,
	input wire xbf_pkg::in_item_t in_data,
	// output beats
	output logic out_valid,
	input wire logic out_ready,
	output xbf_pkg::out_item_t out_data
);
	import xbf_pkg::*;

	logic use_crc_q;
	logic q_valid;
	logic q_pop;
	q_entry_t q_entry;

	// the register write never stalls
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			use_crc_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			use_crc_q <= cfg_data;
		end
	end

	// front: accepts and classifies beats, queues them
	xbf_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.q_valid  (q_valid),
		.q_entry  (q_entry),
		.q_pop    (q_pop)
	);

	// back: builds the blocks and drives the output register
	xbf_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.use_crc   (use_crc_q),
		.q_valid   (q_valid),
		.q_entry   (q_entry),
		.q_pop     (q_pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

`default_nettype wire

### design/xbf_front.sv
// xbf_front: input handshake, item classification and a two-entry queue
// toward the sequencer. Depends on xbf_pkg.
`default_nettype none

module xbf_front (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	input wire xbf_pkg::in_item_t in_data,
	output logic q_valid,
	output xbf_pkg::q_entry_t q_entry,
	input wire logic q_pop
);
	import xbf_pkg::*;

	localparam int PTR_W = $clog2(Q_DEPTH);
	localparam int CNT_W = $clog2(Q_DEPTH + 1);

	q_entry_t mem_q [Q_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic push;
	logic pop;
	q_entry_t new_entry;

	assign in_ready = count_q != CNT_W'(Q_DEPTH);
	assign push = in_valid && in_ready;
	assign pop = q_pop && q_valid;
	assign q_valid = count_q != '0;
	assign q_entry = mem_q[rd_ptr_q];

	// classify the beat
	always_comb begin
		new_entry.op = in_data.cmd ? OP_EOF : OP_DATA;
		new_entry.data_byte = in_data.data_byte;
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= new_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(Q_DEPTH))
		else $error("queue count beyond depth");
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0 && !push) |=> count_q == '0)
		else $error("queue count moved without a push");
	a_push_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> count_q == $past(count_q) + CNT_W'(1))
		else $error("push lost");

endmodule

`default_nettype wire

### design/xbf_back.sv
// xbf_back: block sequencer, checksum and crc accumulators, block state and
// the output register. Depends on xbf_pkg.
`default_nettype none

module xbf_back (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic use_crc,
	input wire logic q_valid,
	input wire xbf_pkg::q_entry_t q_entry,
	output logic q_pop,
	output logic out_valid,
	input wire logic out_ready,
	output xbf_pkg::out_item_t out_data
);
	import xbf_pkg::*;

	typedef enum logic [10:0] {
		S_IDLE   = 11'b000_0000_0001,
		S_SOH    = 11'b000_0000_0010,
		S_NUM    = 11'b000_0000_0100,
		S_CPL    = 11'b000_0000_1000,
		S_DATA   = 11'b000_0001_0000,
		S_PAD    = 11'b000_0010_0000,
		S_PADCRC = 11'b000_0100_0000,
		S_TRL_HI = 11'b000_1000_0000,
		S_TRL_LO = 11'b001_0000_0000,
		S_EOT1   = 11'b010_0000_0000,
		S_EOT2   = 11'b100_0000_0000
	} state_t;

	state_t state_q, state_d;
	logic [FILL_W-1:0] fill_q, fill_d;
	logic [7:0] blk_q, blk_d;
	logic [7:0] sum_q, sum_d;
	logic [15:0] crc_q, crc_d;
	logic [REP_W-1:0] pad_q, pad_d;
	logic [7:0] byte_q;
	logic eof_q;
	logic out_valid_q;
	out_item_t out_q;
	out_item_t beat;
	logic emit_ok;
	logic emit;
	logic item_done;
	logic load;
	logic [FILL_W-1:0] fill_inc;

	assign emit_ok = !out_valid_q || out_ready;
	assign fill_inc = fill_q + FILL_W'(1);
	assign out_valid = out_valid_q;
	assign out_data = out_q;
	assign q_pop = load;

	always_comb begin
		state_d = state_q;
		fill_d = fill_q;
		blk_d = blk_q;
		sum_d = sum_q;
		crc_d = crc_q;
		pad_d = pad_q;
		emit = 1'b0;
		item_done = 1'b0;
		load = 1'b0;
		beat.out_byte = byte_q;
		beat.repeat_count = REP_W'(1);
		beat.block_end = 1'b0;
		beat.last = 1'b0;

		unique case (state_q)
			S_IDLE: begin
				item_done = 1'b1;
			end
			S_SOH: begin
				beat.out_byte = SYM_SOH;
				if (emit_ok) begin
					emit = 1'b1;
					state_d = S_NUM;
				end
			end
			S_NUM: begin
				beat.out_byte = blk_q;
				if (emit_ok) begin
					emit = 1'b1;
					state_d = S_CPL;
				end
			end
			S_CPL: begin
				beat.out_byte = ~blk_q;
				if (emit_ok) begin
					emit = 1'b1;
					state_d = S_DATA;
				end
			end
			S_DATA: begin
				beat.out_byte = byte_q;
				beat.last = fill_inc != FILL_W'(BLOCK_BYTES);
				if (emit_ok) begin
					emit = 1'b1;
					sum_d = sum_q + byte_q;
					crc_d = crc_byte(crc_q, byte_q);
					fill_d = fill_inc;
					if (fill_inc == FILL_W'(BLOCK_BYTES)) begin
						state_d = use_crc ? S_TRL_HI : S_TRL_LO;
					end else begin
						item_done = 1'b1;
					end
				end
			end
			S_PAD: begin
				// one beat stands for the whole run of pad bytes
				beat.out_byte = SYM_PAD;
				beat.repeat_count = REP_W'(FILL_W'(BLOCK_BYTES) - fill_q);
				if (emit_ok) begin
					emit = 1'b1;
					pad_d = REP_W'(FILL_W'(BLOCK_BYTES) - fill_q);
					state_d = S_PADCRC;
				end
			end
			S_PADCRC: begin
				// fold in one pad byte a cycle
				sum_d = sum_q + SYM_PAD;
				crc_d = crc_byte(crc_q, SYM_PAD);
				pad_d = pad_q - REP_W'(1);
				if (pad_q == REP_W'(1)) begin
					state_d = use_crc ? S_TRL_HI : S_TRL_LO;
				end
			end
			S_TRL_HI: begin
				beat.out_byte = crc_q[15:8];
				if (emit_ok) begin
					emit = 1'b1;
					state_d = S_TRL_LO;
				end
			end
			S_TRL_LO: begin
				beat.out_byte = use_crc ? crc_q[7:0] : sum_q;
				beat.block_end = 1'b1;
				beat.last = !eof_q;
				if (emit_ok) begin
					emit = 1'b1;
					blk_d = blk_q + 8'd1;
					fill_d = '0;
					sum_d = '0;
					crc_d = '0;
					if (eof_q) begin
						state_d = S_EOT1;
					end else begin
						item_done = 1'b1;
					end
				end
			end
			S_EOT1: begin
				beat.out_byte = SYM_EOT;
				if (emit_ok) begin
					emit = 1'b1;
					state_d = S_EOT2;
				end
			end
			S_EOT2: begin
				beat.out_byte = SYM_EOT;
				beat.last = 1'b1;
				if (emit_ok) begin
					emit = 1'b1;
					blk_d = 8'd1;
					fill_d = '0;
					sum_d = '0;
					crc_d = '0;
					item_done = 1'b1;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase

		// take the next item straight from the queue when this one is done
		if (item_done) begin
			if (q_valid) begin
				load = 1'b1;
				if (q_entry.op == OP_EOF) begin
					state_d = (fill_d == '0) ? S_EOT1 : S_PAD;
				end else begin
					state_d = (fill_d == '0) ? S_SOH : S_DATA;
				end
			end else begin
				state_d = S_IDLE;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			byte_q <= q_entry.data_byte;
		end
		if (emit) begin
			out_q <= beat;
		end
		pad_q <= pad_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			fill_q <= '0;
			blk_q <= 8'd1;
			sum_q <= '0;
			crc_q <= '0;
			eof_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			fill_q <= fill_d;
			blk_q <= blk_d;
			sum_q <= sum_d;
			crc_q <= crc_d;
			if (load) begin
				eof_q <= q_entry.op == OP_EOF;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	a_fill_range: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FILL_W'(BLOCK_BYTES))
		else $error("fill count beyond block size");
	a_pad_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_PADCRC |-> pad_q != '0)
		else $error("pad counter ran out");
	a_rep_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> out_q.repeat_count != '0)
		else $error("beat with zero repeat count");
	a_trailer_closes: assert property (@(posedge clk) disable iff (!arst_n)
		(emit && state_q == S_TRL_LO) |=> (fill_q == '0 && out_q.block_end))
		else $error("trailer did not close the block");
	a_eot_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		(emit && state_q == S_EOT2) |=> (blk_q == 8'd1 && fill_q == '0))
		else $error("block state not restarted after end of file");

endmodule

`default_nettype wire

### bench/testbench.sv
// testbench: self-checking bench for xmodem_block_framer_top, a directed table
// followed by random files. Depends on xbf_pkg and the framer rtl.
`default_nettype none

module testbench;
	import xbf_pkg::*;

	// row kinds of the directed table
	typedef enum logic {
		ROW_ITEM = 1'b0,
		ROW_MODE = 1'b1
	} row_kind_t;

	// one directed step: an input beat, or a trailer mode write held in val[0]
	typedef struct packed {
		row_kind_t kind;
		op_t op;
		logic [7:0] val;
		logic typed;
		out_item_t beat;
	} row_t;

	localparam int N_ROWS = 21;
	localparam int RAND_ITEMS = 330;
	localparam int SETTLE_CYCLES = 16;
	localparam out_item_t NO_BEAT = '0;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic cfg_data = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	in_item_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	out_item_t out_data;

	// when low both sides run flat out
	logic idle_on = 1'b1;
	int errors = 0;

	// framer state as the bench sees it
	logic crc_mode;
	logic [7:0] blk_num;
	logic [7:0] fill_cnt;
	logic [7:0] sum_acc;
	logic [15:0] crc_acc;

	// line beats still owed by the framer, oldest first
	out_item_t line_beats[$];

	row_t plan [N_ROWS];

	xmodem_block_framer_top DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic out_item_t beat_of(input logic [7:0] b, input logic [REP_W-1:0] rep,
			input logic bend);
		out_item_t o;
		o.out_byte = b;
		o.repeat_count = rep;
		o.block_end = bend;
		o.last = 1'b0;
		return o;
	endfunction

	// crc-16/xmodem one bit at a time, feedback is msb of crc xor the data bit
	function automatic logic [15:0] crc_fold(input logic [15:0] c, input logic [7:0] b);
		logic [15:0] r;
		logic fb;
		r = c;
		for (int k = 7; k >= 0; k--) begin
			fb = r[15] ^ b[k];
			r = {r[14:0], 1'b0};
			if (fb) begin
				r = r ^ CRC_POLY;
			end
		end
		return r;
	endfunction

	// both accumulators run whatever the trailer mode
	function automatic void take_byte(input logic [7:0] b);
		sum_acc = sum_acc + b;
		crc_acc = crc_fold(crc_acc, b);
	endfunction

	function automatic void clear_file();
		blk_num = 8'd1;
		fill_cnt = '0;
		sum_acc = '0;
		crc_acc = '0;
	endfunction

	// trailer picks its form from the mode in force when it goes out
	function automatic void close_block();
		if (crc_mode) begin
			line_beats.push_back(beat_of(crc_acc[15:8], 7'd1, 1'b0));
			line_beats.push_back(beat_of(crc_acc[7:0], 7'd1, 1'b1));
		end else begin
			line_beats.push_back(beat_of(sum_acc, 7'd1, 1'b1));
		end
		blk_num = blk_num + 8'd1;
		fill_cnt = '0;
		sum_acc = '0;
		crc_acc = '0;
	endfunction

	// queue the line beats one accepted input beat causes; a typed beat
	// replaces the first one where it can be read off at a glance
	function automatic void frame_item(input in_item_t it, input logic typed,
			input out_item_t typed_beat);
		int first;
		logic [7:0] pad;
		out_item_t tmp;
		first = line_beats.size();
		if (it.cmd == OP_DATA) begin
			// header ahead of the first byte of a block
			if (fill_cnt == 0) begin
				line_beats.push_back(beat_of(SYM_SOH, 7'd1, 1'b0));
				line_beats.push_back(beat_of(blk_num, 7'd1, 1'b0));
				line_beats.push_back(beat_of(8'hFF - blk_num, 7'd1, 1'b0));
			end
			line_beats.push_back(beat_of(it.data_byte, 7'd1, 1'b0));
			take_byte(it.data_byte);
			fill_cnt = fill_cnt + 8'd1;
			if (fill_cnt == BLOCK_BYTES) begin
				close_block();
			end
		end else begin
			// a partial block is padded out as one beat, then closed
			if (fill_cnt != 0) begin
				pad = 8'(BLOCK_BYTES - fill_cnt);
				line_beats.push_back(beat_of(SYM_PAD, pad[REP_W-1:0], 1'b0));
				repeat (pad) take_byte(SYM_PAD);
				close_block();
			end
			line_beats.push_back(beat_of(SYM_EOT, 7'd1, 1'b0));
			line_beats.push_back(beat_of(SYM_EOT, 7'd1, 1'b0));
			clear_file();
		end
		tmp = line_beats[line_beats.size() - 1];
		tmp.last = 1'b1;
		line_beats[line_beats.size() - 1] = tmp;
		if (typed) begin
			line_beats[first] = typed_beat;
		end
	endfunction

	// all driving tasks start and end at a falling edge
	task automatic send_item(input in_item_t it, input logic typed, input out_item_t typed_beat);
		int gap;
		gap = idle_on ? $urandom_range(0, 4) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		in_data <= it;
		@(posedge clk);
		while (!in_ready) begin
			@(posedge clk);
		end
		frame_item(it, typed, typed_beat);
		@(negedge clk);
	endtask

	task automatic send_data(input logic [7:0] b);
		in_item_t it;
		it.cmd = OP_DATA;
		it.data_byte = b;
		send_item(it, 1'b0, NO_BEAT);
	endtask

	// end of file carries a random ignored data byte
	task automatic send_eof();
		in_item_t it;
		it.cmd = OP_EOF;
		it.data_byte = 8'($urandom_range(0, 255));
		send_item(it, 1'b0, NO_BEAT);
	endtask

	// hold the sender until every owed beat has come, then let the framer settle
	task automatic drain();
		in_valid <= 1'b0;
		while (line_beats.size() != 0) begin
			@(negedge clk);
		end
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// only called with the framer idle
	task automatic write_mode(input logic m);
		cfg_valid <= 1'b1;
		cfg_data <= m;
		@(posedge clk);
		while (!cfg_ready) begin
			@(posedge clk);
		end
		crc_mode = m;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic report_field(input string name, input logic [7:0] want, input logic [7:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
			errors++;
		end
	endtask

	// receiver: random stall ahead of each beat, ready then held until a beat moves
	initial begin : sink
		int stall;
		@(negedge clk);
		forever begin
			stall = idle_on ? $urandom_range(0, 4) : 0;
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
			while (!out_valid) begin
				@(posedge clk);
			end
			@(negedge clk);
		end
	end

	// line checker: every beat that moves is matched against the oldest owed beat
	always @(posedge clk) begin : line_check
		out_item_t want;
		if (arst_n && out_valid && out_ready) begin
			if (line_beats.size() == 0) begin
				$display("%0t: unexpected beat, expected none, got byte %h rep %0d end %b last %b",
					$time, out_data.out_byte, out_data.repeat_count, out_data.block_end,
					out_data.last);
				errors++;
			end else begin
				want = line_beats.pop_front();
				report_field("out_byte", want.out_byte, out_data.out_byte);
				report_field("repeat_count", 8'(want.repeat_count), 8'(out_data.repeat_count));
				report_field("block_end", 8'(want.block_end), 8'(out_data.block_end));
				report_field("last", 8'(want.last), 8'(out_data.last));
			end
		end
	end

	initial begin : stimulus
		in_item_t it;
		int n_rand;
		int len;
		int pick;

		crc_mode = 1'b0;
		clear_file();

		// directed table
		plan = '{
			// after reset, checksum mode
			'{ROW_MODE, OP_DATA, 8'h00, 1'b0, NO_BEAT},
			// empty file: only the two eot beats
			'{ROW_ITEM, OP_EOF, 8'hFF, 1'b1, beat_of(SYM_EOT, 7'd1, 1'b0)},
			'{ROW_ITEM, OP_DATA, 8'h00, 1'b1, beat_of(SYM_SOH, 7'd1, 1'b0)},
			'{ROW_ITEM, OP_DATA, 8'hFF, 1'b0, NO_BEAT},
			'{ROW_ITEM, OP_DATA, 8'h80, 1'b0, NO_BEAT},
			'{ROW_ITEM, OP_DATA, 8'h01, 1'b0, NO_BEAT},
			// four bytes in the block, 124 pad bytes
			'{ROW_ITEM, OP_EOF, 8'h00, 1'b1, beat_of(SYM_PAD, 7'd124, 1'b0)},
			'{ROW_ITEM, OP_DATA, 8'h7F, 1'b1, beat_of(SYM_SOH, 7'd1, 1'b0)},
			// longest pad run
			'{ROW_ITEM, OP_EOF, 8'hA5, 1'b1, beat_of(SYM_PAD, 7'd127, 1'b0)},
			'{ROW_ITEM, OP_EOF, 8'h00, 1'b1, beat_of(SYM_EOT, 7'd1, 1'b0)},
			// crc trailer
			'{ROW_MODE, OP_DATA, 8'h01, 1'b0, NO_BEAT},
			'{ROW_ITEM, OP_DATA, 8'hAA, 1'b1, beat_of(SYM_SOH, 7'd1, 1'b0)},
			'{ROW_ITEM, OP_DATA, 8'h55, 1'b0, NO_BEAT},
			'{ROW_ITEM, OP_EOF, 8'hFF, 1'b0, NO_BEAT},
			// mode flips to checksum with a block open
			'{ROW_ITEM, OP_DATA, 8'h12, 1'b0, NO_BEAT},
			'{ROW_ITEM, OP_DATA, 8'h34, 1'b0, NO_BEAT},
			'{ROW_MODE, OP_DATA, 8'h00, 1'b0, NO_BEAT},
			'{ROW_ITEM, OP_DATA, 8'h56, 1'b0, NO_BEAT},
			'{ROW_ITEM, OP_EOF, 8'h00, 1'b0, NO_BEAT},
			// and back to crc with a block open
			'{ROW_ITEM, OP_DATA, 8'hC3, 1'b0, NO_BEAT},
			'{ROW_MODE, OP_DATA, 8'h01, 1'b0, NO_BEAT}
		};

		// reset held low from the start, released once
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);

		for (int r = 0; r < N_ROWS; r++) begin
			if (plan[r].kind == ROW_MODE) begin
				drain();
				write_mode(plan[r].val[0]);
			end else begin
				it.cmd = plan[r].op;
				it.data_byte = plan[r].val;
				send_item(it, plan[r].typed, plan[r].beat);
			end
		end

		// random files: short ones, ones around the block size, and any length;
		// some segments stop mid-block so the mode can change with a block open
		n_rand = 0;
		while (n_rand < RAND_ITEMS) begin
			drain();
			write_mode(1'($urandom_range(0, 1)));
			idle_on <= ($urandom_range(0, 3) != 0);
			pick = $urandom_range(0, 7);
			if (pick < 4) begin
				len = $urandom_range(0, 6);
			end else if (pick < 6) begin
				len = $urandom_range(BLOCK_BYTES - 2, BLOCK_BYTES + 1);
			end else begin
				len = $urandom_range(0, 140);
			end
			for (int i = 0; i < len; i++) begin
				send_data(8'($urandom_range(0, 255)));
				n_rand++;
				// sender holds off until the line has caught up
				if ($urandom_range(0, 59) == 0) begin
					drain();
				end
			end
			if ($urandom_range(0, 3) != 0) begin
				send_eof();
				n_rand++;
			end
		end

		idle_on <= 1'b1;
		drain();
		if (errors == 0 && line_beats.size() == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

	// run limit, well beyond the slowest legal run
	initial begin : watchdog
		#(64'd30_000_000);
		$display("tb: failure");
		$finish;
	end

endmodule

`default_nettype wire
